>>> hdl/rfdt_pkg.sv
// package for the replica frame distance tracker
// shared constants, controller state type and controller/datapath command structs
`default_nettype none
package rfdt_pkg;
  localparam int MaxFrames = 256;
  localparam int IdxW = $clog2(MaxFrames);
  localparam int CntW = IdxW + 1;
  localparam logic [CntW-1:0] CntOne = 1;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [7:0] BankCount = 8'd3;
  localparam logic [0:0] RegCrcSeed = 1'b0;
  localparam logic [0:0] RegCrcFinal = 1'b1;
  // bytes fed to the crc: 4+4+8+4+8
  localparam int CrcBytes = 28;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CRC, ST_RD, ST_WALK, ST_UPDATE, ST_OUT
  } rfdt_state_t;

  typedef struct packed {
    logic load;       // capture input word, start crc
    logic crc_step;   // one crc byte
    logic rd_issue;   // read store entry at walk index
    logic walk_step;  // compare registered entry
    logic update;     // commit counters and store append
    logic out_load;   // present result word
  } rfdt_cmd_t;

  typedef struct packed {
    logic crc_done;
    logic good;
    logic walk_done;  // last entry issued or store empty
  } rfdt_stat_t;
endpackage
`default_nettype wire

>>> hdl/rfdt_ctrl.sv
// controller state machine for the replica frame distance tracker
// depends on rfdt_pkg
`default_nettype none
module rfdt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               out_busy,
  input  wire rfdt_pkg::rfdt_stat_t stat,
  output rfdt_pkg::rfdt_state_t   state,
  output rfdt_pkg::rfdt_cmd_t     cmd
);
  rfdt_pkg::rfdt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rfdt_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rfdt_pkg::ST_IDLE:   if (in_fire) state_next = rfdt_pkg::ST_CRC;
      rfdt_pkg::ST_CRC: begin
        if (stat.crc_done) begin
          if (stat.good && !stat.walk_done) state_next = rfdt_pkg::ST_RD;
          else state_next = rfdt_pkg::ST_UPDATE;
        end
      end
      rfdt_pkg::ST_RD:     state_next = rfdt_pkg::ST_WALK;
      rfdt_pkg::ST_WALK:   if (stat.walk_done) state_next = rfdt_pkg::ST_UPDATE;
      rfdt_pkg::ST_UPDATE: state_next = rfdt_pkg::ST_OUT;
      rfdt_pkg::ST_OUT:    if (!out_busy) state_next = rfdt_pkg::ST_IDLE;
      default:             state_next = rfdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      rfdt_pkg::ST_IDLE:   cmd.load = in_fire;
      rfdt_pkg::ST_CRC:    cmd.crc_step = !stat.crc_done;
      // first read of the walk, its data is compared in the walk state
      rfdt_pkg::ST_RD:     cmd.rd_issue = 1'b1;
      rfdt_pkg::ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.rd_issue = !stat.walk_done;
      end
      rfdt_pkg::ST_UPDATE: cmd.update = 1'b1;
      rfdt_pkg::ST_OUT:    cmd.out_load = !out_busy;
      default:             cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/rfdt_datapath.sv
// datapath: byte-serial crc, frame store memory, distance walk and counters
// depends on rfdt_pkg; driven by rfdt_ctrl commands
`default_nettype none
module rfdt_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rfdt_pkg::rfdt_cmd_t cmd,
  output rfdt_pkg::rfdt_stat_t     stat,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_sel,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [31:0]         region,
  input  wire logic [7:0]          bank_id,
  input  wire logic [63:0]         vaddr,
  input  wire logic                lookup_ok,
  input  wire logic [63:0]         frame_number,
  output logic [31:0]              page_cnt,
  output logic [31:0]              fail_cnt,
  output logic [31:0]              dup_cnt,
  output logic [31:0]              new_cnt,
  output logic [31:0]              sig_mix,
  output logic [31:0]              sig_sum,
  output logic [2:0]               coverage_mask,
  output logic [63:0]              min_gap_01,
  output logic [63:0]              min_gap_02,
  output logic [63:0]              min_gap_12,
  output logic [63:0]              min_gap_any,
  output logic                     was_duplicate
);
  logic [31:0] crc_seed, crc_final_xor;
  logic [8*rfdt_pkg::CrcBytes-1:0] shreg;
  logic [4:0] byte_cnt;
  logic [31:0] crc;
  logic good;
  logic [1:0] bank;
  logic [63:0] frame;
  logic dup;

  logic [63:0] frame_mem [rfdt_pkg::MaxFrames];
  logic [1:0]  bank_mem  [rfdt_pkg::MaxFrames];
  logic [rfdt_pkg::CntW-1:0] entry_count;
  logic [rfdt_pkg::CntW-1:0] rd_ptr;
  logic [63:0] rd_frame;
  logic [1:0]  rd_bank;

  logic good_in;
  assign good_in = lookup_ok && (bank_id < rfdt_pkg::BankCount);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= '1;
      crc_final_xor <= '1;
    end else if (cfg_we) begin
      if (cfg_sel == rfdt_pkg::RegCrcSeed) crc_seed <= cfg_data;
      else crc_final_xor <= cfg_data;
    end
  end

  // one crc byte per cycle
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int b = 0; b < 8; b++) r = r[0] ? ((r >> 1) ^ rfdt_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= {(good_in ? frame_number : 64'd0), 31'd0, good_in, vaddr,
                24'd0, bank_id, region};
      byte_cnt <= '0;
      crc <= crc_seed;
      good <= good_in;
      bank <= bank_id[1:0];
      frame <= frame_number;
      dup <= 1'b0;
      rd_ptr <= '0;
    end else begin
      if (cmd.crc_step) begin
        crc <= crc_byte(crc, shreg[7:0]);
        shreg <= shreg >> 8;
        byte_cnt <= byte_cnt + 5'd1;
      end
      if (cmd.rd_issue) rd_ptr <= rd_ptr + rfdt_pkg::CntOne;
    end
    if (cmd.walk_step && rd_frame == frame) dup <= 1'b1;
  end

  // registered memory read
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_frame <= frame_mem[rd_ptr[rfdt_pkg::IdxW-1:0]];
      rd_bank  <= bank_mem[rd_ptr[rfdt_pkg::IdxW-1:0]];
    end
    if (cmd.update && good && !dup && !entry_count[rfdt_pkg::IdxW]) begin
      frame_mem[entry_count[rfdt_pkg::IdxW-1:0]] <= frame;
      bank_mem[entry_count[rfdt_pkg::IdxW-1:0]]  <= bank;
    end
  end

  assign stat.crc_done  = (byte_cnt == 5'(rfdt_pkg::CrcBytes));
  assign stat.good      = good;
  assign stat.walk_done = (rd_ptr == entry_count);

  // distance of the entry in the read register
  logic [63:0] gap;
  logic [1:0]  pidx;
  logic        pvalid;
  assign gap = (rd_frame >= frame) ? (rd_frame - frame) : (frame - rd_frame);
  always_comb begin
    pvalid = cmd.walk_step && (rd_bank != bank) && (rd_bank != 2'd3);
    if (rd_bank == 2'd2 || bank == 2'd2) pidx = (rd_bank == 2'd0 || bank == 2'd0) ? 2'd1 : 2'd2;
    else pidx = 2'd0;
  end

  logic [63:0] pgap [3];
  logic [2:0] seen;
  logic [63:0] any_gap;
  logic [31:0] sig;
  assign sig = crc ^ crc_final_xor;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      entry_count <= '0;
      page_cnt <= '0;
      fail_cnt <= '0;
      dup_cnt <= '0;
      new_cnt <= '0;
      sig_mix <= '0;
      sig_sum <= '0;
      any_gap <= '0;
      for (int k = 0; k < 3; k++) pgap[k] <= '0;
    end else begin
      if (pvalid) begin
        if (!seen[pidx] || gap < pgap[pidx]) pgap[pidx] <= gap;
        if (seen == 3'd0 || gap < any_gap) any_gap <= gap;
        seen[pidx] <= 1'b1;
      end
      if (cmd.update) begin
        page_cnt <= page_cnt + 32'd1;
        sig_mix <= sig_mix ^ sig;
        sig_sum <= sig_sum + sig;
        if (!good) fail_cnt <= fail_cnt + 32'd1;
        else if (dup) dup_cnt <= dup_cnt + 32'd1;
        else begin
          new_cnt <= new_cnt + 32'd1;
          if (entry_count[rfdt_pkg::IdxW]) fail_cnt <= fail_cnt + 32'd1;
          else entry_count <= entry_count + rfdt_pkg::CntOne;
        end
      end
    end
  end

  assign coverage_mask = seen;
  assign min_gap_01 = pgap[0];
  assign min_gap_02 = pgap[1];
  assign min_gap_12 = pgap[2];
  assign min_gap_any = any_gap;
  assign was_duplicate = dup;
endmodule
`default_nettype wire

>>> hdl/replica_frame_distance_tracker_core.sv
// top level of the replica frame distance tracker
// usage:
//   s_axis carries one page word; m_axis returns one status word per page.
//   cfg channel writes crc_seed (index 0) or crc_final_xor (index 1);
//   write only while idle.
//   per page: the accept edge, then the byte-serial crc (28 bytes, one a
//   cycle, then a done check), then for a good page with stored frames one
//   read setup state and a walk over every stored frame, then one update
//   state and one output load. the next page can be accepted once the
//   status word is valid.
//   the frame store's single read port sets the walk length.
//   s_axis_tready is high only when the core is idle, so one page is in
//   flight at a time. the result sits in an output register until taken;
//   a stalled receiver holds the core in its output state.
//   reset (rst, synchronous) clears counters, distances, coverage and the
//   store fill count and restores both crc registers to all ones; stored
//   frames are not cleared and need no clearing pass.
//   depends on rfdt_pkg, rfdt_ctrl, rfdt_datapath
`default_nettype none
module replica_frame_distance_tracker_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // region[31:0], bank_id[39:32], vaddr[103:40], lookup_ok[104],
  // frame_number[168:105], zero fill
  input  wire logic [175:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // page_cnt[31:0], fail_cnt[63:32], dup_cnt[95:64], new_cnt[127:96],
  // sig_mix[159:128], sig_sum[191:160], coverage_mask[194:192],
  // min_gap_01[258:195], min_gap_02[322:259], min_gap_12[386:323],
  // min_gap_any[450:387], was_duplicate[451], zero fill
  output logic [455:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  rfdt_pkg::rfdt_state_t state;
  rfdt_pkg::rfdt_cmd_t   cmd;
  rfdt_pkg::rfdt_stat_t  stat;
  logic in_fire;
  logic [451:0] res;

  assign s_axis_tready = (state == rfdt_pkg::ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  rfdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_busy(m_axis_tvalid && !m_axis_tready),
    .stat(stat), .state(state), .cmd(cmd)
  );

  rfdt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_data(cfg_data),
    .region(s_axis_tdata[31:0]), .bank_id(s_axis_tdata[39:32]),
    .vaddr(s_axis_tdata[103:40]), .lookup_ok(s_axis_tdata[104]),
    .frame_number(s_axis_tdata[168:105]),
    .page_cnt(res[31:0]), .fail_cnt(res[63:32]),
    .dup_cnt(res[95:64]), .new_cnt(res[127:96]),
    .sig_mix(res[159:128]), .sig_sum(res[191:160]),
    .coverage_mask(res[194:192]), .min_gap_01(res[258:195]),
    .min_gap_02(res[322:259]), .min_gap_12(res[386:323]),
    .min_gap_any(res[450:387]), .was_duplicate(res[451])
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= {4'd0, res};
  end
endmodule
`default_nettype wire

>>> verif/tb_replica_frame_distance_tracker_core.sv
// testbench for replica_frame_distance_tracker_core: directed table then random pages,
// every status word checked field by field against a cycle-free page tracker model
// depends on rfdt_pkg and replica_frame_distance_tracker_core
`timescale 1ns / 1ps
`default_nettype none
module tb_replica_frame_distance_tracker_core;

  typedef struct packed {
    logic [63:0] frame_number;
    logic        lookup_ok;
    logic [63:0] vaddr;
    logic [7:0]  bank_id;
    logic [31:0] region;
  } page_t;

  typedef struct packed {
    logic        was_duplicate;
    logic [63:0] min_gap_any;
    logic [63:0] min_gap_12;
    logic [63:0] min_gap_02;
    logic [63:0] min_gap_01;
    logic [2:0]  coverage_mask;
    logic [31:0] sig_sum;
    logic [31:0] sig_mix;
    logic [31:0] new_cnt;
    logic [31:0] dup_cnt;
    logic [31:0] fail_cnt;
    logic [31:0] page_cnt;
  } status_t;

  typedef struct {
    page_t   pg;
    logic    has_exp;   // page and failure counts typed in by hand
    logic [31:0] exp_pages;
    logic [31:0] exp_fail;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [455:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  replica_frame_distance_tracker_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // tracker model state
  logic [63:0] trk_frames[rfdt_pkg::MaxFrames];
  logic [1:0]  trk_banks[rfdt_pkg::MaxFrames];
  int unsigned trk_fill;
  logic [31:0] trk_pages, trk_fail, trk_dup, trk_new, trk_mix, trk_sum;
  logic [2:0]  trk_seen;
  logic [63:0] trk_gap[3];
  logic [63:0] trk_gap_any;
  logic [31:0] seed_reg, final_reg;

  status_t expected_status[$];
  int errors = 0;
  int cycles = 0;
  logic hold_off = 0;

  function automatic logic [31:0] crc_feed(logic [31:0] c, logic [63:0] v, int n);
    for (int i = 0; i < n; i++) begin
      c ^= {24'd0, v[7:0]};
      v >>= 8;
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ rfdt_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void note_pair(int a, int b, logic [63:0] gap);
    int lo, hi, k;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    k = (lo == 0) ? ((hi == 1) ? 0 : 1) : 2;
    if (!trk_seen[k] || gap < trk_gap[k]) trk_gap[k] = gap;
    if (trk_seen == 0 || gap < trk_gap_any) trk_gap_any = gap;
    trk_seen[k] = 1'b1;
  endfunction

  function automatic status_t track_page(page_t p);
    status_t r;
    logic good, dup;
    logic [31:0] c;
    logic [63:0] g;
    good = p.lookup_ok && p.bank_id < rfdt_pkg::BankCount;
    dup = 0;
    if (good) begin
      for (int i = 0; i < trk_fill; i++)
        if (trk_banks[i] != p.bank_id[1:0]) begin
          g = trk_frames[i] >= p.frame_number ? trk_frames[i] - p.frame_number
                                              : p.frame_number - trk_frames[i];
          note_pair(trk_banks[i], p.bank_id, g);
        end
      for (int i = 0; i < trk_fill; i++)
        if (trk_frames[i] == p.frame_number) dup = 1;
      if (!dup) begin
        if (trk_fill < rfdt_pkg::MaxFrames) begin
          trk_frames[trk_fill] = p.frame_number;
          trk_banks[trk_fill] = p.bank_id[1:0];
          trk_fill++;
        end else trk_fail++;
      end
    end
    c = crc_feed(seed_reg, {32'd0, p.region}, 4);
    c = crc_feed(c, {56'd0, p.bank_id}, 4);
    c = crc_feed(c, p.vaddr, 8);
    c = crc_feed(c, {63'd0, good}, 4);
    c = crc_feed(c, good ? p.frame_number : 64'd0, 8);
    c ^= final_reg;
    trk_mix ^= c;
    trk_sum += c;
    trk_pages++;
    if (!good) trk_fail++;
    else if (dup) trk_dup++;
    else trk_new++;
    r.page_cnt = trk_pages;
    r.fail_cnt = trk_fail;
    r.dup_cnt = trk_dup;
    r.new_cnt = trk_new;
    r.sig_mix = trk_mix;
    r.sig_sum = trk_sum;
    r.coverage_mask = trk_seen;
    r.min_gap_01 = trk_gap[0];
    r.min_gap_02 = trk_gap[1];
    r.min_gap_12 = trk_gap[2];
    r.min_gap_any = trk_gap_any;
    r.was_duplicate = dup;
    return r;
  endfunction

  // sender: bursts with random gaps, valid stays up inside a burst
  task automatic send_page(page_t p);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, p};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_status.push_back(track_page(p));
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == rfdt_pkg::RegCrcSeed) seed_reg = val;
    else final_reg = val;
    @(posedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic page_t rand_page(int near_frames);
    page_t p;
    p.region = $urandom;
    p.vaddr = {$urandom, $urandom};
    p.lookup_ok = $urandom_range(0, 9) != 0;
    p.bank_id = $urandom_range(0, 19) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
    p.frame_number = near_frames ? 64'($urandom_range(0, 600))
                                 : {$urandom, $urandom};
    return p;
  endfunction

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_axis_tready <= hold_off ? 1'b0 : ((cycles % 7) < 4 || $urandom_range(0, 2) == 0);
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_status.size() == 0) begin
        $error("status word with no page pending");
        errors++;
      end else begin
        status_t e, a;
        e = expected_status.pop_front();
        a = status_t'(m_axis_tdata[451:0]);
        if (a.page_cnt !== e.page_cnt) begin
          $error("page_cnt exp %0h got %0h", e.page_cnt, a.page_cnt); errors++; end
        if (a.fail_cnt !== e.fail_cnt) begin
          $error("fail_cnt exp %0h got %0h", e.fail_cnt, a.fail_cnt); errors++; end
        if (a.dup_cnt !== e.dup_cnt) begin
          $error("dup_cnt exp %0h got %0h", e.dup_cnt, a.dup_cnt); errors++; end
        if (a.new_cnt !== e.new_cnt) begin
          $error("new_cnt exp %0h got %0h", e.new_cnt, a.new_cnt); errors++; end
        if (a.sig_mix !== e.sig_mix) begin
          $error("sig_mix exp %0h got %0h", e.sig_mix, a.sig_mix); errors++; end
        if (a.sig_sum !== e.sig_sum) begin
          $error("sig_sum exp %0h got %0h", e.sig_sum, a.sig_sum); errors++; end
        if (a.coverage_mask !== e.coverage_mask) begin
          $error("coverage_mask exp %0h got %0h", e.coverage_mask, a.coverage_mask); errors++; end
        if (a.min_gap_01 !== e.min_gap_01) begin
          $error("min_gap_01 exp %0h got %0h", e.min_gap_01, a.min_gap_01); errors++; end
        if (a.min_gap_02 !== e.min_gap_02) begin
          $error("min_gap_02 exp %0h got %0h", e.min_gap_02, a.min_gap_02); errors++; end
        if (a.min_gap_12 !== e.min_gap_12) begin
          $error("min_gap_12 exp %0h got %0h", e.min_gap_12, a.min_gap_12); errors++; end
        if (a.min_gap_any !== e.min_gap_any) begin
          $error("min_gap_any exp %0h got %0h", e.min_gap_any, a.min_gap_any); errors++; end
        if (a.was_duplicate !== e.was_duplicate) begin
          $error("was_duplicate exp %0h got %0h", e.was_duplicate, a.was_duplicate); errors++; end
      end
    end
    if (cycles > 600000) begin
      $display("tb_replica_frame_distance_tracker_core: errors");
      $finish;
    end
  end

  initial begin
    repeat (600) @(posedge clk);
    wait (cycles > 3000);
    @(posedge clk) hold_off <= 1;
    repeat (1500) @(posedge clk);
    hold_off <= 0;
  end

  row_t dir_rows[$];

  task automatic add_row(logic [31:0] rg, logic [7:0] bk, logic [63:0] ad, logic ok,
                         logic [63:0] fr, logic chk, logic [31:0] pgs, logic [31:0] fl);
    row_t r;
    r.pg = '{frame_number: fr, lookup_ok: ok, vaddr: ad, bank_id: bk, region: rg};
    r.has_exp = chk;
    r.exp_pages = pgs;
    r.exp_fail = fl;
    dir_rows.push_back(r);
  endtask

  initial begin
    trk_fill = 0;
    {trk_pages, trk_fail, trk_dup, trk_new, trk_mix, trk_sum} = '0;
    trk_seen = 0;
    trk_gap = '{default: 64'd0};
    trk_gap_any = 0;
    seed_reg = '1;
    final_reg = '1;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // bad pages first: failure count is easy to read off
    add_row(32'h0, 8'd0, 64'h0, 1'b0, 64'h0, 1, 1, 1);
    add_row('1, 8'd3, '1, 1'b1, '1, 1, 2, 2);
    add_row(32'h5a5a, 8'hff, 64'h1, 1'b1, 64'h10, 1, 3, 3);
    // first good page, then pair distances and extremes
    add_row(32'h1, 8'd0, 64'h1000, 1'b1, 64'd100, 1, 4, 3);
    add_row(32'h1, 8'd0, 64'h2000, 1'b1, 64'd90, 0, 0, 0);     // same bank, no gap
    add_row(32'h2, 8'd1, 64'h3000, 1'b1, 64'd130, 0, 0, 0);
    add_row(32'h3, 8'd2, '1, 1'b1, '1, 0, 0, 0);
    add_row(32'h3, 8'd2, 64'h0, 1'b1, 64'd0, 0, 0, 0);
    add_row(32'h4, 8'd1, 64'h4, 1'b1, 64'd100, 0, 0, 0);      // duplicate across banks
    add_row(32'h4, 8'd0, 64'h4, 1'b1, 64'd100, 0, 0, 0);      // duplicate same bank
    add_row(32'h5, 8'd2, 64'h5, 1'b0, 64'd100, 0, 0, 0);
    add_row('1, 8'd1, '1, 1'b1, 64'h8000_0000_0000_0000, 0, 0, 0);
    foreach (dir_rows[i]) begin
      send_page(dir_rows[i].pg);
      // typed counts replace the tracker's for this word
      if (dir_rows[i].has_exp) begin
        expected_status[expected_status.size() - 1].page_cnt = dir_rows[i].exp_pages;
        expected_status[expected_status.size() - 1].fail_cnt = dir_rows[i].exp_fail;
      end
    end
    drain();
    write_reg(rfdt_pkg::RegCrcSeed, 32'h0);
    write_reg(rfdt_pkg::RegCrcFinal, 32'h0);
    for (int i = 0; i < 150; i++) send_page(rand_page(1));
    drain();
    write_reg(rfdt_pkg::RegCrcSeed, $urandom);
    write_reg(rfdt_pkg::RegCrcFinal, $urandom);
    // fill the store past its end to reach the store-full path
    for (int i = 0; i < 300; i++) send_page(rand_page(i % 3 == 0));
    drain();
    write_reg(rfdt_pkg::RegCrcSeed, '1);
    write_reg(rfdt_pkg::RegCrcFinal, '1);
    for (int i = 0; i < 20; i++) send_page(rand_page(1));
    drain();
    if (errors == 0) begin
      $display("tb_replica_frame_distance_tracker_core: clean");
    end else begin
      $display("tb_replica_frame_distance_tracker_core: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
